// File: hdl/gble_pkg.sv
// Shared constants and types for the gray, blur and Laplacian edge stream.
package gble_pkg;

    localparam int DEF_MAX_WIDTH = 2048;

    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;
    localparam int WIDTH_W  = 12;
    localparam int HEIGHT_W = 16;
    localparam int ROW_W    = HEIGHT_W + 1;

    localparam logic [WIDTH_W-1:0]  DEF_IMAGE_WIDTH  = 12'd640;
    localparam logic [HEIGHT_W-1:0] DEF_IMAGE_HEIGHT = 16'd480;

    // gray = floor((299*c0 + 587*c1 + 114*c2) / 1000), division by reciprocal
    localparam int SUM_W = 18;
    localparam logic [SUM_W-1:0] WEIGHT_CHAN0 = 18'd299;
    localparam logic [SUM_W-1:0] WEIGHT_CHAN1 = 18'd587;
    localparam logic [SUM_W-1:0] WEIGHT_CHAN2 = 18'd114;
    localparam int RECIP_W    = 19;
    localparam int PROD_W     = SUM_W + RECIP_W;
    localparam int GRAY_SHIFT = 28;
    localparam logic [RECIP_W-1:0] GRAY_RECIP = 19'd268436;

    typedef enum logic {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } reg_sel_t;

    // one word of a line store: two rows above the current one
    typedef struct packed {
        logic [7:0] older;
        logic [7:0] newer;
    } line_pair_t;

    typedef struct packed {
        logic [7:0] top;
        logic [7:0] mid;
        logic [7:0] bot;
        logic       col_edge;
        logic       row_edge;
        logic       row_edge_next;
    } gray_col_t;

    typedef struct packed {
        logic [7:0] top;
        logic [7:0] mid;
        logic [7:0] bot;
        logic       col_edge;
        logic       row_edge;
    } blur_col_t;

    typedef struct packed {
        logic valid;
        logic emit;
        logic frame_end;
    } step_t;

endpackage

// File: hdl/gray_blur_laplacian_edge_stream_top.sv
// Top level: colour to gray, 3x3 binomial blur and 3x3 Laplacian on a pixel stream.
//
// Accepts one transfer per clock when not stalled and returns one edge byte per
// pixel in raster order. Each pixel is converted to gray, blurred with the 1-2-1
// by 1-2-1 kernel and passed through the 8-neighbour Laplacian; pixels on the
// frame border keep their gray value. The result for raster position n leaves
// with the pixel that brings the count to n+2W+3, so output trails input by 2W+2
// pixels; once the frame is complete, each flush transfer (mode 1) drains one of
// the remaining 2W+2 results, and frame_end marks the last one. A pixel sent
// while results are still pending is dropped, a flush on an incomplete frame does
// nothing. Results pass the st1 to st3 and output registers. Two line stores of
// MAX_WIDTH words (gray and blurred rows) each take one read and one write per
// cycle, which sets the rate of one pixel per clock; output stall holds the whole
// pipeline. Writing image_width or image_height restarts the frame.
module gray_blur_laplacian_edge_stream_top #(
    parameter int MAX_WIDTH = gble_pkg::DEF_MAX_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gble_pkg::PADDR_W-1:0]  paddr,
    input  logic [gble_pkg::PDATA_W-1:0]  pwdata,
    output logic [gble_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    input  logic                          pixel_valid,
    output logic                          pixel_stall,
    input  logic                          mode,
    input  logic [7:0]                    chan0,
    input  logic [7:0]                    chan1,
    input  logic [7:0]                    chan2,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [7:0]                    edge_value,
    output logic                          frame_end
);

    import gble_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic                cfg_write;
    reg_sel_t            cfg_sel;
    logic [CW-1:0]       w_last;
    logic [ROW_W-1:0]    h_ext;

    logic [CW-1:0]    col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    logic adv;
    logic complete;
    logic step;
    logic emit0;
    logic fe0;
    logic cedge0;
    logic redge0;
    logic rnext0;
    logic [SUM_W-1:0] wsum;

    step_t            st1_reg, st2_reg, st3_reg;
    logic [SUM_W-1:0] s1_reg;
    logic [CW-1:0]    col1_reg;
    logic             cedge1_reg;
    logic             redge1_reg;
    logic             rnext1_reg;

    line_pair_t        g_rd, g_wr;
    logic [PROD_W-1:0] gprod;
    logic [7:0]        gray_val;
    gray_col_t         gwin_reg [3];
    logic [CW-1:0]     gnew_col_reg;
    logic [CW-1:0]     bcol2_reg;

    line_pair_t  b_rd, b_wr;
    logic [11:0] bsum;
    logic        bborder;
    logic [7:0]  blur_val;
    blur_col_t   bwin_reg [3];

    logic       eborder;
    logic [7:0] nsum;
    logic [7:0] edge_calc;

    logic       result_valid_reg;
    logic [7:0] edge_value_reg;
    logic       frame_end_reg;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_sel   = reg_sel_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DEF_IMAGE_WIDTH;
            height_reg <= DEF_IMAGE_HEIGHT;
        end
        else if (cfg_write)
        begin
            unique case (cfg_sel)
                REG_IMAGE_WIDTH:  width_reg  <= pwdata[WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= pwdata[HEIGHT_W-1:0];
                default:          width_reg  <= width_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            REG_IMAGE_WIDTH:  prdata = PDATA_W'(width_reg);
            REG_IMAGE_HEIGHT: prdata = PDATA_W'(height_reg);
            default:          prdata = '0;
        endcase
    end

    always_comb
    begin
        if (width_reg < WIDTH_W'(3))
        begin
            w_last = CW'(2);
        end
        else if (32'(width_reg) > MAX_WIDTH)
        begin
            w_last = CW'(MAX_WIDTH - 1);
        end
        else
        begin
            w_last = CW'(width_reg - WIDTH_W'(1));
        end
    end

    assign h_ext = (height_reg < HEIGHT_W'(3)) ? ROW_W'(3) : ROW_W'(height_reg);

    // stage 0: position of this step, gray line store read
    assign adv         = !result_valid_reg || !result_stall;
    assign pixel_stall = !adv;
    assign complete    = row_reg >= h_ext;
    assign step        = pixel_valid && adv && (mode == complete);
    assign emit0       = (row_reg >= ROW_W'(3)) || (row_reg == ROW_W'(2) && col_reg >= CW'(2));
    assign fe0         = (row_reg == h_ext + ROW_W'(2)) && (col_reg == CW'(1));
    assign cedge0      = (col_reg == '0) || (col_reg == w_last);
    assign redge0      = (row_reg == ROW_W'(1)) || (row_reg == h_ext);
    assign rnext0      = (row_reg == ROW_W'(2)) || (row_reg == h_ext + ROW_W'(1));
    assign wsum        = SUM_W'(chan0) * WEIGHT_CHAN0
                       + SUM_W'(chan1) * WEIGHT_CHAN1
                       + SUM_W'(chan2) * WEIGHT_CHAN2;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        priority if (cfg_write)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (step)
        begin
            if (fe0)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (col_reg == w_last)
            begin
                col_next = '0;
                row_next = row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg          <= '0;
            row_reg          <= '0;
            st1_reg          <= '0;
            st2_reg          <= '0;
            st3_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (adv)
            begin
                st1_reg          <= {step, emit0, fe0};
                st2_reg          <= st1_reg;
                st3_reg          <= st2_reg;
                result_valid_reg <= st3_reg.valid && st3_reg.emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg     <= wsum;
            col1_reg   <= col_reg;
            cedge1_reg <= cedge0;
            redge1_reg <= redge0;
            rnext1_reg <= rnext0;
        end
    end

    gble_ram #(
        .WIDTH ($bits(line_pair_t)),
        .DEPTH (MAX_WIDTH)
    ) u_gray_rows (
        .clk   (clk),
        .we    (st1_reg.valid && adv),
        .waddr (col1_reg),
        .wdata (g_wr),
        .re    (step),
        .raddr (col_reg),
        .rdata (g_rd)
    );

    // stage 1: gray value, gray line store write-back, gray window shift
    assign gprod    = PROD_W'(s1_reg) * PROD_W'(GRAY_RECIP);
    assign gray_val = gprod[GRAY_SHIFT+7:GRAY_SHIFT];
    assign g_wr     = {g_rd.newer, gray_val};

    always_ff @(posedge clk)
    begin
        if (st1_reg.valid && adv)
        begin
            gwin_reg[0]  <= gwin_reg[1];
            gwin_reg[1]  <= gwin_reg[2];
            gwin_reg[2]  <= {g_rd.older, g_rd.newer, gray_val,
                             cedge1_reg, redge1_reg, rnext1_reg};
            gnew_col_reg <= col1_reg;
            bcol2_reg    <= gnew_col_reg;
        end
    end

    gble_ram #(
        .WIDTH ($bits(line_pair_t)),
        .DEPTH (MAX_WIDTH)
    ) u_blur_rows (
        .clk   (clk),
        .we    (st2_reg.valid && adv),
        .waddr (bcol2_reg),
        .wdata (b_wr),
        .re    (st1_reg.valid && adv),
        .raddr (gnew_col_reg),
        .rdata (b_rd)
    );

    // stage 2: blur on the gray window centre, blur line store write-back, blur window shift
    assign bsum = 12'({gwin_reg[1].mid, 2'b00})
                + 12'({gwin_reg[1].top, 1'b0}) + 12'({gwin_reg[1].bot, 1'b0})
                + 12'({gwin_reg[0].mid, 1'b0}) + 12'({gwin_reg[2].mid, 1'b0})
                + 12'(gwin_reg[0].top) + 12'(gwin_reg[0].bot)
                + 12'(gwin_reg[2].top) + 12'(gwin_reg[2].bot);
    assign bborder  = gwin_reg[1].col_edge || gwin_reg[1].row_edge;
    assign blur_val = bborder ? gwin_reg[1].mid : bsum[11:4];
    assign b_wr     = {b_rd.newer, blur_val};

    always_ff @(posedge clk)
    begin
        if (st2_reg.valid && adv)
        begin
            bwin_reg[0] <= bwin_reg[1];
            bwin_reg[1] <= bwin_reg[2];
            bwin_reg[2] <= {b_rd.older, b_rd.newer, blur_val,
                            gwin_reg[1].col_edge, gwin_reg[1].row_edge_next};
        end
    end

    // stage 3: Laplacian, low byte
    assign eborder   = bwin_reg[1].col_edge || bwin_reg[1].row_edge;
    assign nsum      = bwin_reg[0].top + bwin_reg[0].mid + bwin_reg[0].bot
                     + bwin_reg[1].top + bwin_reg[1].bot
                     + bwin_reg[2].top + bwin_reg[2].mid + bwin_reg[2].bot;
    assign edge_calc = eborder ? bwin_reg[1].mid : ({bwin_reg[1].mid[4:0], 3'b000} - nsum);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            edge_value_reg <= edge_calc;
            frame_end_reg  <= st3_reg.frame_end;
        end
    end

    assign result_valid = result_valid_reg;
    assign edge_value   = edge_value_reg;
    assign frame_end    = frame_end_reg;

endmodule

// File: hdl/gble_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module gble_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: tb/tb.sv
// Testbench for gray_blur_laplacian_edge_stream_top: self-checking random and directed frames.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gble_pkg::*;

    localparam int   MAX_W      = DEF_MAX_WIDTH;
    localparam int   RING_ROWS  = 8;
    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;
    localparam int   SETTLE     = 12;
    localparam int   HOLD_LEN   = 300;

    typedef struct {
        logic [7:0] edge_value;
        logic       frame_end;
    } edge_out_t;

    class edge_predictor;
        logic [7:0]          gray_ring [RING_ROWS*MAX_W];
        logic [WIDTH_W-1:0]  width_reg;
        logic [HEIGHT_W-1:0] height_reg;
        int                  col;
        int                  row;
        int                  emitted;
        int                  frames_done;
        int                  mismatches;
        edge_out_t           pending_edges [$];

        function new();
            foreach (gray_ring[i])
                gray_ring[i] = 8'd0;
            width_reg   = DEF_IMAGE_WIDTH;
            height_reg  = DEF_IMAGE_HEIGHT;
            col         = 0;
            row         = 0;
            emitted     = 0;
            frames_done = 0;
            mismatches  = 0;
        endfunction

        function int cols();
            int w;
            w = int'(width_reg);
            if (w < 3)
                w = 3;
            if (w > MAX_W)
                w = MAX_W;
            return w;
        endfunction

        function int rows();
            return (height_reg < 3) ? 3 : int'(height_reg);
        endfunction

        function bit complete();
            return row >= rows();
        endfunction

        function bit busy();
            return pending_edges.size() != 0;
        endfunction

        // any register write restarts the frame
        function void set_reg(reg_sel_t sel, logic [31:0] value);
            if (sel == REG_IMAGE_WIDTH)
                width_reg = value[WIDTH_W-1:0];
            else
                height_reg = value[HEIGHT_W-1:0];
            col     = 0;
            row     = 0;
            emitted = 0;
        endfunction

        function int gray_px(int y, int x);
            return int'(gray_ring[(y % RING_ROWS)*MAX_W + x]);
        endfunction

        function int blur_px(int y, int x, int w, int h);
            int s;
            if (y == 0 || y == h-1 || x == 0 || x == w-1)
                return gray_px(y, x);
            s = 4*gray_px(y, x)
              + 2*(gray_px(y-1, x) + gray_px(y+1, x) + gray_px(y, x-1) + gray_px(y, x+1))
              + gray_px(y-1, x-1) + gray_px(y-1, x+1)
              + gray_px(y+1, x-1) + gray_px(y+1, x+1);
            return s >> 4;
        endfunction

        function int edge_px(int r, int c, int w, int h);
            int s;
            s = 0;
            if (r == 0 || r == h-1 || c == 0 || c == w-1)
                return gray_px(r, c);
            for (int dy = -1; dy <= 1; dy++)
                for (int dx = -1; dx <= 1; dx++)
                    if (dy != 0 || dx != 0)
                        s += blur_px(r+dy, c+dx, w, h);
            return (8*blur_px(r, c, w, h) - s) & 255;
        endfunction

        // returns 0 for a transfer the block ignores
        function bit take_item(logic m, logic [7:0] c0, logic [7:0] c1, logic [7:0] c2);
            int        w;
            int        h;
            int        total;
            int        delay;
            int        received;
            bit        done;
            bit        ready;
            bit        used;
            edge_out_t e;
            w     = cols();
            h     = rows();
            total = w*h;
            delay = 2*w + 2;
            done  = complete();
            used  = 1'b1;
            if (m == MODE_PIXEL) begin
                if (done)
                    return 1'b0;
                gray_ring[(row % RING_ROWS)*MAX_W + col] = (299*c0 + 587*c1 + 114*c2) / 1000;
                col++;
                if (col >= w) begin
                    col = 0;
                    row++;
                end
                done = complete();
            end
            else if (!done) begin
                used = 1'b0;
            end
            received = done ? total : row*w + col;
            ready    = done ? (emitted < total) : (emitted + delay < received);
            if (!ready)
                return used;
            e.edge_value = 8'(edge_px(emitted / w, emitted % w, w, h));
            emitted++;
            e.frame_end = (emitted >= total);
            if (e.frame_end) begin
                row     = 0;
                col     = 0;
                emitted = 0;
                frames_done++;
            end
            pending_edges.push_back(e);
            return used;
        endfunction

        function void match_edge(logic [7:0] ev, logic fe);
            edge_out_t e;
            if (pending_edges.size() == 0) begin
                $display("%0t: unexpected transfer, actual edge_value %02h frame_end %0b",
                         $time, ev, fe);
                mismatches++;
                return;
            end
            e = pending_edges.pop_front();
            if (ev !== e.edge_value) begin
                $display("%0t: edge_value expected %02h actual %02h", $time, e.edge_value, ev);
                mismatches++;
            end
            if (fe !== e.frame_end) begin
                $display("%0t: frame_end expected %0b actual %0b", $time, e.frame_end, fe);
                mismatches++;
            end
        endfunction
    endclass

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                psel         = 1'b0;
    logic                penable      = 1'b0;
    logic                pwrite       = 1'b0;
    logic [PADDR_W-1:0]  paddr        = '0;
    logic [PDATA_W-1:0]  pwdata       = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                pixel_valid  = 1'b0;
    logic                pixel_stall;
    logic                mode         = MODE_PIXEL;
    logic [7:0]          chan0        = '0;
    logic [7:0]          chan1        = '0;
    logic [7:0]          chan2        = '0;
    logic                result_valid;
    logic                result_stall = 1'b0;
    logic [7:0]          edge_value;
    logic                frame_end;

    edge_predictor sb;
    bit            idle_on      = 1'b1;
    int            hold_cycles  = 0;
    int            random_items = 0;

    gray_blur_laplacian_edge_stream_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .mode         (mode),
        .chan0        (chan0),
        .chan1        (chan1),
        .chan2        (chan2),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .edge_value   (edge_value),
        .frame_end    (frame_end)
    );

    always #5 clk = ~clk;

    initial
    begin
        #10_000_000;
        $display("FAIL gray_blur_laplacian_edge_stream_top");
        $finish;
    end

    task automatic apb_access(reg_sel_t sel, bit wr, logic [31:0] wdata,
                              output logic [31:0] rdata);
        logic rdy;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {sel, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(negedge clk);
            rdy   = pready;
            rdata = prdata;
            @(posedge clk);
        end
        while (!rdy);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic read_check(reg_sel_t sel, logic [31:0] expected);
        logic [31:0] rd;
        apb_access(sel, 1'b0, '0, rd);
        if (rd !== expected) begin
            $display("%0t: %s readback expected %0d actual %0d", $time, sel.name(), expected, rd);
            sb.mismatches++;
        end
    endtask

    task automatic write_reg(reg_sel_t sel, logic [31:0] value);
        logic [31:0] rd;
        apb_access(sel, 1'b1, value, rd);
        sb.set_reg(sel, value);
        read_check(sel, (sel == REG_IMAGE_WIDTH) ? {20'd0, value[WIDTH_W-1:0]}
                                                 : {16'd0, value[HEIGHT_W-1:0]});
    endtask

    task automatic send(logic m, logic [7:0] a, logic [7:0] b, logic [7:0] d, output bit used);
        int   gap;
        logic st;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            pixel_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_valid <= 1'b1;
        mode        <= m;
        chan0       <= a;
        chan1       <= b;
        chan2       <= d;
        do
        begin
            @(negedge clk);
            st = pixel_stall;
            @(posedge clk);
        end
        while (st);
        used = sb.take_item(m, a, b, d);
    endtask

    task automatic quiesce();
        pixel_valid <= 1'b0;
        @(posedge clk);
        while (sb.busy()) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // mostly well-formed frames, with stray flushes and pixels mixed in
    task automatic run_frames(int n_frames, int abort_at, int pause_at, int hold_at);
        int         n;
        int         first;
        bit         used;
        logic       m;
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] d;
        n     = 0;
        first = sb.frames_done;
        while (sb.frames_done - first < n_frames && n != abort_at) begin
            if (n == hold_at)
                hold_cycles = HOLD_LEN;
            if (n == pause_at) begin
                pixel_valid <= 1'b0;
                @(posedge clk);
                while (sb.busy()) @(posedge clk);
            end
            if (sb.complete())
                m = ($urandom_range(0, 15) == 0) ? MODE_PIXEL : MODE_FLUSH;
            else
                m = ($urandom_range(0, 15) == 0) ? MODE_FLUSH : MODE_PIXEL;
            a = 8'($urandom);
            b = 8'($urandom);
            d = 8'($urandom);
            send(m, a, b, d, used);
            random_items += used;
            n++;
        end
    endtask

    initial
    begin
        int         gap;
        logic       v;
        logic [7:0] ev;
        logic       fe;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_cycles > 0) begin
                result_stall <= 1'b1;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
            end
            gap = idle_on ? $urandom_range(0, 3) : 0;
            if (gap > 0) begin
                result_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            result_stall <= 1'b0;
            do
            begin
                @(negedge clk);
                v  = result_valid;
                ev = edge_value;
                fe = frame_end;
                @(posedge clk);
            end
            while (!v);
            sb.match_edge(ev, fe);
        end
    end

    initial
    begin
        logic [7:0]  dir_c0 [9];
        logic [7:0]  dir_c1 [9];
        logic [7:0]  dir_c2 [9];
        int          p;
        int          pick;
        int          abort_at;
        logic [31:0] wv;
        logic [31:0] hv;
        logic [1:0]  which;
        bit          used;
        dir_c0 = '{8'd0, 8'd255, 8'd255, 8'd0,   8'd0,   8'd255, 8'd0,   8'd255, 8'd128};
        dir_c1 = '{8'd0, 8'd255, 8'd0,   8'd255, 8'd0,   8'd255, 8'd255, 8'd0,   8'd64};
        dir_c2 = '{8'd0, 8'd255, 8'd0,   8'd0,   8'd255, 8'd0,   8'd255, 8'd255, 8'd32};
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset sizes: long enough for the first results of row 0
        read_check(REG_IMAGE_WIDTH, {20'd0, DEF_IMAGE_WIDTH});
        read_check(REG_IMAGE_HEIGHT, {16'd0, DEF_IMAGE_HEIGHT});
        for (int i = 0; i < 1290; i++)
            send(MODE_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom), used);
        quiesce();

        // smallest frame: flush before data, colour extremes, pixel after completion
        write_reg(REG_IMAGE_WIDTH, 32'd3);
        write_reg(REG_IMAGE_HEIGHT, 32'd3);
        send(MODE_FLUSH, 8'd0, 8'd0, 8'd0, used);
        for (int i = 0; i < 9; i++)
            send(MODE_PIXEL, dir_c0[i], dir_c1[i], dir_c2[i], used);
        send(MODE_PIXEL, 8'hFF, 8'h00, 8'hFF, used);
        for (int i = 0; i < 8; i++)
            send(MODE_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom), used);
        quiesce();

        // sizes below the minimum are clamped
        write_reg(REG_IMAGE_WIDTH, 32'd2);
        write_reg(REG_IMAGE_HEIGHT, 32'd0);
        run_frames(1, -1, -1, -1);
        quiesce();

        // widest frame
        write_reg(REG_IMAGE_WIDTH, 32'd4095);
        write_reg(REG_IMAGE_HEIGHT, 32'd1);
        run_frames(1, -1, -1, -1);
        quiesce();

        // tallest frame, aborted part way
        write_reg(REG_IMAGE_WIDTH, 32'd5);
        write_reg(REG_IMAGE_HEIGHT, 32'd65535);
        run_frames(1, 300, -1, -1);
        quiesce();

        random_items = 0;
        for (p = 0; random_items < 1750; p++) begin
            pick = $urandom_range(0, 7);
            case (pick)
                0:       wv = $urandom_range(0, 2);
                1:       wv = $urandom_range(13, 64);
                default: wv = $urandom_range(3, 12);
            endcase
            hv    = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
            which = (p < 3) ? 2'b11 : 2'($urandom_range(0, 3));
            if (which[0])
                write_reg(REG_IMAGE_WIDTH, wv);
            if (which[1])
                write_reg(REG_IMAGE_HEIGHT, hv);
            idle_on  = (p < 3) || ($urandom_range(0, 3) != 0);
            abort_at = (p >= 3 && $urandom_range(0, 4) == 0)
                     ? $urandom_range(0, sb.cols()*sb.rows()) : -1;
            run_frames($urandom_range(1, 3), abort_at, (p == 2) ? 12 : -1, (p == 1) ? 4 : -1);
            quiesce();
        end

        repeat (20) @(posedge clk);
        if (sb.mismatches == 0 && !sb.busy())
            $display("PASS gray_blur_laplacian_edge_stream_top");
        else
            $display("FAIL gray_blur_laplacian_edge_stream_top");
        $finish;
    end

endmodule

// File: filelist.f
hdl/gble_pkg.sv
hdl/gble_ram.sv
hdl/gray_blur_laplacian_edge_stream_top.sv
tb/tb.sv
